### rtl/rmt_pkg.sv
// ----------------------------------------------------------------------------
// rmt_pkg
// Shared types and constants for the running median tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package rmt_pkg;

  // sample and median width
  localparam int unsigned DataW = 32;
  // width of the reported sample count
  localparam int unsigned HeldW = 9;
  // cells merged by one first-level tap group
  localparam int unsigned GroupSize = 16;

  // insertion beat broadcast along the cell chain
  typedef struct packed {
    logic                    en;
    logic signed [DataW-1:0] x;
  } insert_t;

endpackage

`default_nettype wire

### rtl/rmt_cell.sv
// ----------------------------------------------------------------------------
// rmt_cell
// One slot of the sorted insertion chain. Holds one sample, shifts up from
// its lower neighbor or captures the new sample, and taps its value out when
// it sits at one of the two median positions.
// ----------------------------------------------------------------------------
`default_nettype none

module rmt_cell
  import rmt_pkg::*;
#(
  parameter int unsigned CntW  = 9,
  parameter int unsigned Index = 0
) (
  input  wire logic                    clk_i,
  input  wire insert_t                 ins_i,
  input  wire logic [CntW-1:0]         n_i,
  input  wire logic [CntW-1:0]         lo_idx_i,
  input  wire logic [CntW-1:0]         hi_idx_i,
  input  wire logic signed [DataW-1:0] left_val_i,
  input  wire logic                    left_gt_i,
  output logic signed [DataW-1:0]      val_o,
  output logic                         gt_o,
  output logic        [DataW-1:0]      tap_lo_o,
  output logic        [DataW-1:0]      tap_hi_o
);

  localparam logic [CntW-1:0] Idx = CntW'(Index);

  logic signed [DataW-1:0] val_q, val_d;

  // occupied slot holding a value above the new sample
  assign gt_o = (Idx < n_i) && (val_q > ins_i.x);

  // shift up, take the new sample, or hold
  always_comb begin
    val_d = val_q;
    if (ins_i.en) begin
      if (left_gt_i) begin
        val_d = left_val_i;
      end else if (gt_o || (Idx == n_i)) begin
        val_d = ins_i.x;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

  // gated taps for the median select tree
  assign tap_lo_o = (Idx == lo_idx_i) ? val_q : '0;
  assign tap_hi_o = (Idx == hi_idx_i) ? val_q : '0;

endmodule

`default_nettype wire

### rtl/running_median_tracker_unit.sv
// ----------------------------------------------------------------------------
// running_median_tracker_unit
// Running median of a stream of signed 32-bit samples.
// ----------------------------------------------------------------------------
// Samples are kept in ascending order in a chain of CAPACITY cells; a new
// sample is placed by every cell comparing against it and shifting up from
// its neighbor. One sample is accepted per cycle while the output side takes
// results. Each result passes three registers in order: the cells take the
// sample at the edge that accepts it, one group level of the median select
// tree is registered after that, and the output register then loads the
// final merge and the 33-bit midpoint sum.
// restart empties the store before its own sample goes in. A sample that
// meets a full store is dropped and flagged with store_full, and the median
// of the held samples is reported. For an even count the median is
// median_floor plus one half when median_half is set.
// ----------------------------------------------------------------------------
`default_nettype none

module running_median_tracker_unit
  import rmt_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic signed [DataW-1:0] sample_i,
  input  wire logic                    restart_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [DataW-1:0]      median_floor_o,
  output logic                         median_half_o,
  output logic        [HeldW-1:0]      held_count_o,
  output logic                         store_full_o
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned NGrp  = (CAPACITY + GroupSize - 1) / GroupSize;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  // handshake and global advance
  logic advance, accept;
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;
  assign accept     = in_valid_i && advance;

  // count after restart, full check
  logic [CntW-1:0] count_q, count_d, n_eff;
  logic            full_q, full_d, drop;
  insert_t         ins;

  assign n_eff      = restart_i ? '0 : count_q;
  assign drop       = (n_eff >= CapCnt);
  assign ins.en     = accept && !drop;
  assign ins.x      = sample_i;

  always_comb begin
    count_d = count_q;
    full_d  = full_q;
    if (accept) begin
      count_d = drop ? CapCnt : n_eff + CntW'(1);
      full_d  = drop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      full_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      full_q  <= full_d;
    end
  end

  // median positions from the stored count
  logic [CntW-1:0] hi_idx, lo_idx;
  assign hi_idx = count_q >> 1;
  assign lo_idx = count_q[0] ? hi_idx : hi_idx - CntW'(1);

  // sorted insertion chain
  logic signed [DataW-1:0] cell_val [CAPACITY];
  logic                    cell_gt  [CAPACITY];
  logic        [DataW-1:0] tap_lo   [CAPACITY];
  logic        [DataW-1:0] tap_hi   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DataW-1:0] left_val;
    logic                    left_gt;
    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_rest
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end
    rmt_cell #(
      .CntW  (CntW),
      .Index (i)
    ) u_cell (
      .clk_i      (clk_i),
      .ins_i      (ins),
      .n_i        (n_eff),
      .lo_idx_i   (lo_idx),
      .hi_idx_i   (hi_idx),
      .left_val_i (left_val),
      .left_gt_i  (left_gt),
      .val_o      (cell_val[i]),
      .gt_o       (cell_gt[i]),
      .tap_lo_o   (tap_lo[i]),
      .tap_hi_o   (tap_hi[i])
    );
  end

  // cells hold a placed beat whose median is not yet tapped
  logic s0_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (advance) begin
      s0_valid_q <= accept;
    end
  end

  // first select level: registered group merges
  logic [DataW-1:0] grp_lo_q [NGrp];
  logic [DataW-1:0] grp_hi_q [NGrp];

  for (genvar g = 0; g < NGrp; g++) begin : g_grp
    logic [DataW-1:0] acc_lo, acc_hi;
    always_comb begin
      acc_lo = '0;
      acc_hi = '0;
      for (int k = 0; k < GroupSize; k++) begin
        if (g * GroupSize + k < CAPACITY) begin
          acc_lo = acc_lo | tap_lo[g * GroupSize + k];
          acc_hi = acc_hi | tap_hi[g * GroupSize + k];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (advance) begin
        grp_lo_q[g] <= acc_lo;
        grp_hi_q[g] <= acc_hi;
      end
    end
  end

  // stage one control
  logic            s1_valid_q;
  logic [CntW-1:0] s1_count_q;
  logic            s1_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_count_q <= count_q;
      s1_full_q  <= full_q;
    end
  end

  // final merge and midpoint
  logic [DataW-1:0] med_lo, med_hi;
  logic [DataW:0]   mid_sum;

  always_comb begin
    med_lo = '0;
    med_hi = '0;
    for (int g = 0; g < NGrp; g++) begin
      med_lo = med_lo | grp_lo_q[g];
      med_hi = med_hi | grp_hi_q[g];
    end
  end

  assign mid_sum = {med_lo[DataW-1], med_lo} + {med_hi[DataW-1], med_hi};

  // output register
  logic            out_valid_q;
  logic [CntW-1:0] out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      median_floor_o <= mid_sum[DataW:1];
      median_half_o  <= mid_sum[0];
      out_count_q    <= s1_count_q;
      store_full_o   <= s1_full_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign held_count_o = HeldW'(out_count_q);

  // checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("stored count above capacity");

  a_restart_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && restart_i |=> count_q == CntW'(1))
    else $error("restart did not leave a single sample");

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && store_full_o |-> out_count_q == CapCnt)
    else $error("full flag without a full store");

  a_grow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !restart_i && (count_q < CapCnt) |=> count_q == $past(count_q) + CntW'(1))
    else $error("count did not grow on insertion");

endmodule

`default_nettype wire
